FILE: sv/hcar_pkg.sv
// Shared constants, register codes and the auto-repeat table for the cursor unit.
package hcar_pkg;

	localparam int CUR_W       = 7;
	localparam int TICK_W      = 16;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_FIELD_W = 2 * CUR_W + 4 * TICK_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int PADDR_W     = 3;

	// Register index, taken from paddr[2].
	typedef enum logic {
		REG_MAX_X = 1'b0,
		REG_MAX_Y = 1'b1
	} reg_idx_t;

	localparam logic [CUR_W-1:0] MAX_X_RST = 7'd127;
	localparam logic [CUR_W-1:0] MAX_Y_RST = 7'd31;

	// Switch order within the switch nibble of the level byte.
	localparam int SW_RIGHT = 0;
	localparam int SW_DOWN  = 1;
	localparam int SW_UP    = 2;
	localparam int SW_LEFT  = 3;

	// Step for a hold count: lo carries the count whenever above_60 is low.
	function automatic logic [1:0] repeat_amt(input logic above_60, input logic [5:0] lo);
		logic [1:0] amt;
		amt = 2'd0;
		if (above_60) begin
			amt = {1'b0, ~lo[0]};
		end else begin
			case (lo) inside
				6'd1: amt = 2'd3;
				6'd18, 6'd24, 6'd30,
				6'd33, 6'd36, 6'd39, 6'd42, 6'd45,
				6'd48, 6'd51, 6'd54, 6'd57, 6'd60: amt = 2'd1;
				default: amt = 2'd0;
			endcase
		end
		return amt;
	endfunction

endpackage

FILE: sv/hcar_skid.sv
// Two-entry output buffer: result register plus skid register.
module hcar_skid #(
	parameter int WIDTH = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             out_valid_q;
	logic [WIDTH-1:0] out_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;

	assign in_ready  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			// output stalled: park the new transfer
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_data_q <= in_data;
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_ready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to output");

	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid_q)
		else $error("accepted transfer lost");
`endif

endmodule

FILE: sv/hold_timed_cursor_auto_repeat_unit.sv
// Top level of the hold-timed cursor unit with auto-repeat.
// Every transfer on the input stream is one polling tick; the unit takes one tick per clock
// cycle while the output buffer has room, and its result is registered in that buffer. The
// hold counters, opposite-switch check, repeat step and clamp are all combinational between
// the state registers and the result register. A two-entry output buffer keeps ticks flowing
// while a result waits; input ready drops only once both entries are full. The user must
// write max_x and max_y over the APB port only while idle; the block does not enforce it.
module hold_timed_cursor_auto_repeat_unit #(
	parameter int HOLD_COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] pressed_levels
	input  logic [hcar_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [6:0] cursor_col, [13:7] cursor_row, [29:14] button1_ticks, [45:30] button2_ticks,
	// [61:46] button3_ticks, [77:62] button4_ticks, [79:78] zero
	output logic [hcar_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hcar_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int W = HOLD_COUNT_WIDTH;
	localparam int CW = hcar_pkg::CUR_W;

	logic [CW-1:0] max_x_q, max_y_q;
	logic [CW-1:0] cur_x_q, cur_y_q;
	logic [W-1:0]  btn_q [4];
	logic [W-1:0]  sw_q  [4];

	logic [W-1:0]  btn_nxt [4];
	logic [W-1:0]  sw_bump [4];
	logic [W-1:0]  sw_nxt  [4];
	logic [1:0]    amt     [4];
	logic          lr_clash, ud_clash;
	logic signed [CW+1:0] nx, ny;
	logic [CW-1:0] cx_nxt, cy_nxt;
	logic [7:0]    levels;
	logic          accept;
	logic          cfg_wr;
	hcar_pkg::reg_idx_t reg_idx;
	logic [hcar_pkg::OUT_TDATA_W-1:0] result;

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = hcar_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		prdata = 32'd0;
		case (reg_idx)
			hcar_pkg::REG_MAX_X: prdata = 32'(max_x_q);
			hcar_pkg::REG_MAX_Y: prdata = 32'(max_y_q);
			default:             prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= hcar_pkg::MAX_X_RST;
			max_y_q <= hcar_pkg::MAX_Y_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				hcar_pkg::REG_MAX_X: max_x_q <= pwdata[CW-1:0];
				hcar_pkg::REG_MAX_Y: max_y_q <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- tick update ----------------
	assign levels = s_tdata[7:0];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			btn_nxt[i] = levels[i]     ? btn_q[i] + W'(1) : '0;
			sw_bump[i] = levels[i + 4] ? sw_q[i]  + W'(1) : '0;
		end
		lr_clash = (sw_bump[hcar_pkg::SW_LEFT] != '0) && (sw_bump[hcar_pkg::SW_RIGHT] != '0);
		ud_clash = (sw_bump[hcar_pkg::SW_UP] != '0) && (sw_bump[hcar_pkg::SW_DOWN] != '0);
		for (int i = 0; i < 4; i++) begin
			sw_nxt[i] = sw_bump[i];
		end
		if (lr_clash) begin
			sw_nxt[hcar_pkg::SW_LEFT]  = '0;
			sw_nxt[hcar_pkg::SW_RIGHT] = '0;
		end
		if (ud_clash) begin
			sw_nxt[hcar_pkg::SW_UP]   = '0;
			sw_nxt[hcar_pkg::SW_DOWN] = '0;
		end
		for (int i = 0; i < 4; i++) begin
			amt[i] = hcar_pkg::repeat_amt(sw_nxt[i] > W'(60), sw_nxt[i][5:0]);
		end
	end

	always_comb begin
		nx = $signed({2'b00, cur_x_q}) + $signed({7'd0, amt[hcar_pkg::SW_RIGHT]})
		     - $signed({7'd0, amt[hcar_pkg::SW_LEFT]});
		ny = $signed({2'b00, cur_y_q}) + $signed({7'd0, amt[hcar_pkg::SW_DOWN]})
		     - $signed({7'd0, amt[hcar_pkg::SW_UP]});
		// clamp to 0..max on each axis
		if (nx[CW+1])                          cx_nxt = '0;
		else if (nx[CW:0] > {1'b0, max_x_q})   cx_nxt = max_x_q;
		else                                   cx_nxt = nx[CW-1:0];
		if (ny[CW+1])                          cy_nxt = '0;
		else if (ny[CW:0] > {1'b0, max_y_q})   cy_nxt = max_y_q;
		else                                   cy_nxt = ny[CW-1:0];
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			for (int i = 0; i < 4; i++) begin
				btn_q[i] <= '0;
				sw_q[i]  <= '0;
			end
		end else if (accept) begin
			cur_x_q <= cx_nxt;
			cur_y_q <= cy_nxt;
			for (int i = 0; i < 4; i++) begin
				btn_q[i] <= btn_nxt[i];
				sw_q[i]  <= sw_nxt[i];
			end
		end
	end

	assign result = {
		{(hcar_pkg::OUT_TDATA_W - hcar_pkg::OUT_FIELD_W){1'b0}},
		hcar_pkg::TICK_W'(btn_nxt[3]),
		hcar_pkg::TICK_W'(btn_nxt[2]),
		hcar_pkg::TICK_W'(btn_nxt[1]),
		hcar_pkg::TICK_W'(btn_nxt[0]),
		cy_nxt,
		cx_nxt
	};

	hcar_skid #(
		.WIDTH(hcar_pkg::OUT_TDATA_W)
	) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (result),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

`ifndef SYNTHESIS
	a_lr_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!((sw_q[hcar_pkg::SW_LEFT] != '0) && (sw_q[hcar_pkg::SW_RIGHT] != '0)))
		else $error("left and right both counting");

	a_ud_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!((sw_q[hcar_pkg::SW_UP] != '0) && (sw_q[hcar_pkg::SW_DOWN] != '0)))
		else $error("up and down both counting");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_idx == hcar_pkg::REG_MAX_X) |=> (max_x_q == $past(pwdata[CW-1:0])))
		else $error("max_x write not taken");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (cur_x_q <= max_x_q))
		else $error("column beyond max_x after tick");
`endif

endmodule

FILE: dv/hold_timed_cursor_auto_repeat_unit_tb.sv
// Self-checking testbench for the hold-timed auto-repeat cursor unit.
module hold_timed_cursor_auto_repeat_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 2000;

	// Tracks hold counters, cursor and limits; holds the results still owed by the unit.
	class cursor_scoreboard;
		typedef struct packed {
			logic [hcar_pkg::CUR_W-1:0]       col;
			logic [hcar_pkg::CUR_W-1:0]       row;
			logic [3:0][hcar_pkg::TICK_W-1:0] ticks;
		} tick_result_t;

		logic [hcar_pkg::CUR_W-1:0]  col_limit, row_limit, col, row;
		logic [hcar_pkg::TICK_W-1:0] btn_hold [4];
		logic [hcar_pkg::TICK_W-1:0] sw_hold [4];
		tick_result_t                owed_q [$];
		int                          mismatches;
		int                          results_seen;

		function new();
			col_limit = hcar_pkg::MAX_X_RST;
			row_limit = hcar_pkg::MAX_Y_RST;
			col = '0;
			row = '0;
			foreach (btn_hold[i]) begin
				btn_hold[i] = '0;
				sw_hold[i] = '0;
			end
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void write_reg(hcar_pkg::reg_idx_t idx, logic [31:0] data);
			case (idx)
				hcar_pkg::REG_MAX_X: col_limit = data[hcar_pkg::CUR_W-1:0];
				hcar_pkg::REG_MAX_Y: row_limit = data[hcar_pkg::CUR_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [hcar_pkg::CUR_W-1:0] limit_of(hcar_pkg::reg_idx_t idx);
			return (idx == hcar_pkg::REG_MAX_X) ? col_limit : row_limit;
		endfunction

		function int repeat_step(logic [hcar_pkg::TICK_W-1:0] t);
			if (t == 0) return 0;
			if (t == 1) return 3;
			if (t >= 15 && t <= 30) return int'(t % 6 == 0);
			if (t >= 31 && t <= 60) return int'(t % 3 == 0);
			if (t > 60) return int'(!t[0]);
			return 0;
		endfunction

		function logic [hcar_pkg::CUR_W-1:0] pin_to_range(int v,
				logic [hcar_pkg::CUR_W-1:0] top);
			if (v < 0) return '0;
			if (v > int'(top)) return top;
			return v[hcar_pkg::CUR_W-1:0];
		endfunction

		function void note_tick(logic [7:0] lv);
			tick_result_t r;
			int nx, ny;
			for (int i = 0; i < 4; i++) begin
				btn_hold[i] = lv[i] ? btn_hold[i] + 1'b1 : '0;
				sw_hold[i] = lv[i+4] ? sw_hold[i] + 1'b1 : '0;
			end
			// opposite switches cancel each other
			if (sw_hold[hcar_pkg::SW_LEFT] != 0 && sw_hold[hcar_pkg::SW_RIGHT] != 0) begin
				sw_hold[hcar_pkg::SW_LEFT] = '0;
				sw_hold[hcar_pkg::SW_RIGHT] = '0;
			end
			if (sw_hold[hcar_pkg::SW_UP] != 0 && sw_hold[hcar_pkg::SW_DOWN] != 0) begin
				sw_hold[hcar_pkg::SW_UP] = '0;
				sw_hold[hcar_pkg::SW_DOWN] = '0;
			end
			nx = int'(col) - repeat_step(sw_hold[hcar_pkg::SW_LEFT])
				+ repeat_step(sw_hold[hcar_pkg::SW_RIGHT]);
			ny = int'(row) - repeat_step(sw_hold[hcar_pkg::SW_UP])
				+ repeat_step(sw_hold[hcar_pkg::SW_DOWN]);
			col = pin_to_range(nx, col_limit);
			row = pin_to_range(ny, row_limit);
			r.col = col;
			r.row = row;
			for (int i = 0; i < 4; i++) r.ticks[i] = btn_hold[i];
			owed_q.push_back(r);
		endfunction

		function void check_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
			end
		endfunction

		function void check_result(logic [hcar_pkg::OUT_TDATA_W-1:0] data);
			tick_result_t r;
			results_seen++;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %h arrived with no tick outstanding", $realtime, data);
				return;
			end
			r = owed_q.pop_front();
			check_field("cursor_col", r.col, data[6:0]);
			check_field("cursor_row", r.row, data[13:7]);
			check_field("button1_ticks", r.ticks[0], data[29:14]);
			check_field("button2_ticks", r.ticks[1], data[45:30]);
			check_field("button3_ticks", r.ticks[2], data[61:46]);
			check_field("button4_ticks", r.ticks[3], data[77:62]);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [hcar_pkg::IN_TDATA_W-1:0]  s_tdata;   // [7:0] pressed_levels
	logic                             m_tvalid;
	logic                             m_tready;
	// [6:0] cursor_col, [13:7] cursor_row, [29:14] button1_ticks, [45:30] button2_ticks,
	// [61:46] button3_ticks, [77:62] button4_ticks, [79:78] zero
	logic [hcar_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [hcar_pkg::PADDR_W-1:0]     paddr;
	logic [31:0]                      pwdata;
	logic [31:0]                      prdata;
	logic                             pready;

	cursor_scoreboard sb = new();
	bit calm;
	int stuck = 0;
	int ticks_sent = 0;
	int settings = 0;

	hold_timed_cursor_auto_repeat_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Results are checked before the tick of the same edge is noted: a result always
	// belongs to an earlier tick.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (s_tvalid && s_tready) sb.note_tick(s_tdata);
			if (psel && penable && pwrite && pready)
				sb.write_reg(hcar_pkg::reg_idx_t'(paddr[2]), pwdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) stuck <= 0;
			else stuck <= stuck + 1;
		end
	end

	initial begin
		wait (stuck >= STUCK_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: stall a random number of cycles before each transfer.
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			gap = calm ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Enter and leave at a falling edge; keep tvalid high across back-to-back ticks.
	task automatic send_tick(input logic [7:0] lv);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= lv;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		ticks_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() > 0) @(negedge clk);
	endtask

	task automatic write_limit(input hcar_pkg::reg_idx_t idx,
			input logic [hcar_pkg::CUR_W-1:0] val);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {25'($urandom()), val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.check_field(idx == hcar_pkg::REG_MAX_X ? "max_x readback" : "max_y readback",
			sb.limit_of(idx), rd);
	endtask

	task automatic set_limits(input logic [hcar_pkg::CUR_W-1:0] x,
			input logic [hcar_pkg::CUR_W-1:0] y);
		drain();
		repeat (3) @(negedge clk);
		write_limit(hcar_pkg::REG_MAX_X, x);
		write_limit(hcar_pkg::REG_MAX_Y, y);
		settings++;
	endtask

	// Mostly held switch patterns of random length with random buttons; some noise.
	task automatic run_random(input int n);
		int done, len, sel;
		logic [3:0] sw, btn;
		done = 0;
		while (done < n) begin
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 24) == 0) drain();
			if ($urandom_range(0, 9) < 2) begin
				len = $urandom_range(1, 8);
				repeat (len) send_tick(8'($urandom()));
			end else begin
				sel = $urandom_range(0, 7);
				if (sel < 4) sw = 4'b0001 << sel;
				else case (sel)
					4: sw = 4'b0011;
					5: sw = 4'b1100;
					6: sw = 4'($urandom());
					default: sw = 4'b0000;
				endcase
				case ($urandom_range(0, 3))
					0, 1: len = $urandom_range(1, 16);
					2: len = $urandom_range(15, 70);
					default: len = $urandom_range(60, 140);
				endcase
				btn = 4'($urandom());
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 15) == 0) btn[2'($urandom_range(0, 3))] ^= 1'b1;
					// drop the switches for one tick now and then
					send_tick({($urandom_range(0, 39) == 0) ? 4'h0 : sw, btn});
				end
			end
			done += len;
		end
	endtask

	initial begin
		logic [7:0] opening [$] = '{8'h00, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'h10, 8'h20, 8'h40,
			8'h40, 8'h80, 8'h80, 8'h00, 8'h80, 8'h40, 8'h90, 8'h60, 8'hA5, 8'h5A,
			8'h01, 8'h02, 8'h04, 8'h08, 8'h00};
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening[i]) send_tick(opening[i]);
		run_random(120);
		set_limits(7'd0, 7'd0);
		run_random(120);
		set_limits(7'd127, 7'd127);
		// push the cursor into the far corner
		calm = 1'b1;
		repeat (300) send_tick({4'h3, 4'($urandom())});
		run_random(120);
		// lowered limits pull the stored cursor in
		set_limits(7'd5, 7'd3);
		run_random(120);
		set_limits(7'($urandom()), 7'($urandom()));
		run_random(120);
		set_limits(7'($urandom()), 7'($urandom()));
		run_random(120);
		set_limits(7'd127, 7'd31);
		run_random(120);

		// hold buttons and two switches for a long run
		calm = 1'b1;
		repeat (100) send_tick(8'h3F);
		repeat (4) send_tick(8'h00);

		drain();
		repeat (8) @(negedge clk);
		$display("Sent %0d ticks over %0d limit settings, checked %0d results.",
			ticks_sent, settings + 1, sb.results_seen);
		$display("Covered clamping at both ends, opposite switches and long holds.");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/hcar_pkg.sv
sv/hcar_skid.sv
sv/hold_timed_cursor_auto_repeat_unit.sv
dv/hold_timed_cursor_auto_repeat_unit_tb.sv
